/* hw/rtl/rtgl_pkg.sv */
package rtgl_pkg;

    localparam int ADDR_W = 32;
    localparam int INTF_W = 4;

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOROUTE = 2'd1,
        ST_LOOP    = 2'd2
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gw;
        logic [INTF_W-1:0] intf;
    } route_entry_t;

endpackage

/* hw/rtl/rtgl_table.sv */
module rtgl_table #(
    parameter int ENTRIES = 16,
    parameter int IDX_W   = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [IDX_W-1:0]       wr_idx,
    input  logic                   wr_valid,
    input  rtgl_pkg::route_entry_t wr_entry,
    input  logic [IDX_W-1:0]       rd_idx,
    output logic                   rd_valid,
    output rtgl_pkg::route_entry_t rd_entry
);
    import rtgl_pkg::*;

    route_entry_t             mem [ENTRIES];
    logic [ENTRIES-1:0]       valid_reg;
    logic                     rd_valid_reg;
    route_entry_t             rd_entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= wr_valid;
            end
            rd_valid_reg <= valid_reg[rd_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_entry;
        end
        rd_entry_reg <= mem[rd_idx];
    end

    assign rd_valid = rd_valid_reg;
    assign rd_entry = rd_entry_reg;

endmodule

/* hw/rtl/route_table_gateway_lookup.sv */
// First-match route lookup with gateway chasing. A request with mode 1 writes one table
// entry (ignored when entry_index is at or beyond ROUTE_ENTRIES or route_interface is at or
// beyond NUM_INTERFACES) and presents status 0 by way of S_FIN. A request with mode 0 scans
// the table in order from entry 0 through a single registered read port, one entry per
// cycle, and restarts the scan at each gateway hop, up to MAX_HOPS hops (at most MAX_HOPS + 1
// scans). A lookup ends in S_FIN with status 0 on a hit with no gateway, status 2 on a
// gateway hit at the hop limit or status 1 when no entry matches; from S_FIN the result
// moves to the output register once that is free, and the next request is taken only back
// in S_IDLE. in_stall stays high while a request is in progress; a finished result waits
// in the output register while the next request enters.
module route_table_gateway_lookup #(
    parameter int ROUTE_ENTRIES  = 16,
    parameter int MAX_HOPS       = 10,
    parameter int NUM_INTERFACES = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [3:0]  entry_index,
    input  logic        entry_valid,
    input  logic [31:0] addr,
    input  logic [31:0] dest_mask,
    input  logic [31:0] route_gateway,
    input  logic [3:0]  route_interface,
    input  logic [3:0]  start_depth,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [3:0]  out_interface,
    output logic [31:0] next_hop
);
    import rtgl_pkg::*;

    localparam int IDX_W   = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ROUTE_ENTRIES + 1);
    localparam int DEPTH_W = ($clog2(MAX_HOPS + 1) > 4) ? $clog2(MAX_HOPS + 1) : 4;
    localparam logic [CNT_W-1:0]   LAST_CNT   = CNT_W'(ROUTE_ENTRIES);
    localparam logic [DEPTH_W-1:0] HOP_LIMIT  = DEPTH_W'(MAX_HOPS);
    localparam logic [8:0]         ENTRY_LIM  = 9'(ROUTE_ENTRIES);
    localparam logic [8:0]         INTF_LIM   = 9'(NUM_INTERFACES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   cur_addr_reg, cur_addr_next;
    logic [DEPTH_W-1:0]  depth_reg, depth_next;
    logic                first_reg, first_next;
    logic [ADDR_W-1:0]   hop_reg, hop_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                pend_reg, pend_next;
    status_t             res_status_reg, res_status_next;
    logic [INTF_W-1:0]   res_intf_reg, res_intf_next;
    logic [ADDR_W-1:0]   res_hop_reg, res_hop_next;
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [INTF_W-1:0]   out_intf_reg, out_intf_next;
    logic [ADDR_W-1:0]   next_hop_reg, next_hop_next;

    logic                accept;
    logic                wr_en;
    logic [8:0]          wr_idx_ext;
    logic [8:0]          wr_intf_ext;
    route_entry_t        wr_entry;
    logic                rd_valid;
    route_entry_t        rd_entry;
    logic                hit;

    assign accept      = in_valid && !in_stall;
    assign wr_idx_ext  = {5'd0, entry_index};
    assign wr_intf_ext = {5'd0, route_interface};
    assign wr_en       = accept && (mode == MODE_WRITE) && (wr_idx_ext < ENTRY_LIM)
                         && (wr_intf_ext < INTF_LIM);
    assign wr_entry    = '{dest: addr, mask: dest_mask, gw: route_gateway,
                           intf: route_interface};

    rtgl_table #(
        .ENTRIES (ROUTE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_idx   (wr_idx_ext[IDX_W-1:0]),
        .wr_valid (entry_valid),
        .wr_entry (wr_entry),
        .rd_idx   (cnt_reg[IDX_W-1:0]),
        .rd_valid (rd_valid),
        .rd_entry (rd_entry)
    );

    assign hit = pend_reg && rd_valid && (rd_entry.dest == (cur_addr_reg & rd_entry.mask));

    always_comb
    begin
        state_next      = state_reg;
        cur_addr_next   = cur_addr_reg;
        depth_next      = depth_reg;
        first_next      = first_reg;
        hop_next        = hop_reg;
        cnt_next        = cnt_reg;
        pend_next       = pend_reg;
        res_status_next = res_status_reg;
        res_intf_next   = res_intf_reg;
        res_hop_next    = res_hop_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        out_intf_next   = out_intf_reg;
        next_hop_next   = next_hop_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == MODE_WRITE)
                    begin
                        res_status_next = ST_OK;
                        res_intf_next   = '0;
                        res_hop_next    = '0;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        cur_addr_next = addr;
                        depth_next    = DEPTH_W'(start_depth);
                        first_next    = 1'b1;
                        hop_next      = '0;
                        cnt_next      = '0;
                        pend_next     = 1'b0;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                priority if (hit)
                begin
                    if (rd_entry.gw == '0)
                    begin
                        res_status_next = ST_OK;
                        res_intf_next   = rd_entry.intf;
                        res_hop_next    = hop_reg;
                        state_next      = S_FIN;
                    end
                    else if (depth_reg >= HOP_LIMIT)
                    begin
                        res_status_next = ST_LOOP;
                        res_intf_next   = '0;
                        res_hop_next    = '0;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        // chase the gateway: restart the scan one hop deeper
                        if (first_reg)
                        begin
                            hop_next = rd_entry.gw;
                        end
                        first_next    = 1'b0;
                        cur_addr_next = rd_entry.gw;
                        depth_next    = DEPTH_W'(depth_reg + 1'b1);
                        cnt_next      = '0;
                        pend_next     = 1'b0;
                    end
                end
                else if (pend_reg && (cnt_reg == LAST_CNT))
                begin
                    res_status_next = ST_NOROUTE;
                    res_intf_next   = '0;
                    res_hop_next    = '0;
                    state_next      = S_FIN;
                end
                else
                begin
                    cnt_next  = CNT_W'(cnt_reg + 1'b1);
                    pend_next = 1'b1;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_status_reg;
                    out_intf_next  = res_intf_reg;
                    next_hop_next  = res_hop_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            pend_reg       <= 1'b0;
            cnt_reg        <= '0;
            first_reg      <= 1'b1;
            depth_reg      <= '0;
            res_status_reg <= ST_OK;
            status_reg     <= ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            pend_reg       <= pend_next;
            cnt_reg        <= cnt_next;
            first_reg      <= first_next;
            depth_reg      <= depth_next;
            res_status_reg <= res_status_next;
            status_reg     <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_addr_reg <= cur_addr_next;
        hop_reg      <= hop_next;
        res_intf_reg <= res_intf_next;
        res_hop_reg  <= res_hop_next;
        out_intf_reg <= out_intf_next;
        next_hop_reg <= next_hop_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign out_interface = out_intf_reg;
    assign next_hop      = next_hop_reg;

endmodule

/* tb/tb_top.sv */
module tb_top;
    import rtgl_pkg::*;

    localparam int TBL_DEPTH       = 16;
    localparam int HOP_LIMIT       = 10;
    localparam int INTF_COUNT      = 16;
    localparam int POOL_SIZE       = 8;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int HOLD_CYCLES     = 400;
    localparam int IDLE_LIMIT      = 4000;
    localparam int TAIL_CYCLES     = 250;
    localparam int REPORT_MAX      = 10;
    localparam int DIR_ROWS        = 25;

    typedef struct {
        logic        mode;
        logic [3:0]  idx;
        logic        valid;
        logic [31:0] addr;
        logic [31:0] mask;
        logic [31:0] gw;
        logic [3:0]  intf;
        logic [3:0]  depth;
    } route_req_t;

    typedef struct {
        status_t     status;
        logic [3:0]  intf;
        logic [31:0] hop;
    } route_result_t;

    typedef struct {
        route_req_t    req;
        bit            typed;
        route_result_t res;
    } dir_row_t;

    logic        clk             = 1'b0;
    logic        rst_n           = 1'b0;
    logic        in_valid        = 1'b0;
    logic        in_stall;
    logic        mode            = 1'b0;
    logic [3:0]  entry_index     = 4'd0;
    logic        entry_valid     = 1'b0;
    logic [31:0] addr            = 32'h0;
    logic [31:0] dest_mask       = 32'h0;
    logic [31:0] route_gateway   = 32'h0;
    logic [3:0]  route_interface = 4'd0;
    logic [3:0]  start_depth     = 4'd0;
    logic        out_valid;
    logic        out_stall       = 1'b0;
    logic [1:0]  status;
    logic [3:0]  out_interface;
    logic [31:0] next_hop;

    logic        rt_valid [TBL_DEPTH];
    logic [31:0] rt_dest  [TBL_DEPTH];
    logic [31:0] rt_mask  [TBL_DEPTH];
    logic [31:0] rt_gw    [TBL_DEPTH];
    logic [3:0]  rt_intf  [TBL_DEPTH];

    logic [31:0]   addr_pool [POOL_SIZE];
    dir_row_t      dir_rows [DIR_ROWS];
    route_result_t pending_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_phase     = 1'b0;
    bit hold_used      = 1'b0;
    int hold_cnt       = 0;
    int idle_cycles    = 0;
    int fail_cnt       = 0;
    int n_write        = 0;
    int n_routed       = 0;
    int n_noroute      = 0;
    int n_loop         = 0;

    route_table_gateway_lookup u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .mode            (mode),
        .entry_index     (entry_index),
        .entry_valid     (entry_valid),
        .addr            (addr),
        .dest_mask       (dest_mask),
        .route_gateway   (route_gateway),
        .route_interface (route_interface),
        .start_depth     (start_depth),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .out_interface   (out_interface),
        .next_hop        (next_hop)
    );

    always #6 clk = ~clk;

    function automatic route_result_t route_predict(route_req_t r);
        route_result_t res;
        logic [31:0]   a;
        int            depth;
        int            e;
        bit            first;
        bit            done;
        res.status = ST_OK;
        res.intf   = 4'd0;
        res.hop    = 32'h0;
        if (r.mode == MODE_WRITE) begin
            if (int'(r.idx) < TBL_DEPTH && int'(r.intf) < INTF_COUNT) begin
                rt_valid[r.idx] = r.valid;
                rt_dest[r.idx]  = r.addr;
                rt_mask[r.idx]  = r.mask;
                rt_gw[r.idx]    = r.gw;
                rt_intf[r.idx]  = r.intf;
            end
        end
        else begin
            a     = r.addr;
            depth = int'(r.depth);
            first = 1'b1;
            done  = 1'b0;
            while (!done) begin
                e = -1;
                for (int i = TBL_DEPTH - 1; i >= 0; i--)
                    if (rt_valid[i] && rt_dest[i] == (a & rt_mask[i]))
                        e = i;
                if (e < 0) begin
                    res.status = ST_NOROUTE;
                    done       = 1'b1;
                end
                else if (rt_gw[e] == 32'h0) begin
                    res.intf = rt_intf[e];
                    done     = 1'b1;
                end
                else if (depth >= HOP_LIMIT) begin
                    res.status = ST_LOOP;
                    done       = 1'b1;
                end
                else begin
                    if (first)
                        res.hop = rt_gw[e];
                    first = 1'b0;
                    a     = rt_gw[e];
                    depth++;
                end
            end
            if (res.status != ST_OK) begin
                res.intf = 4'd0;
                res.hop  = 32'h0;
            end
        end
        return res;
    endfunction

    function automatic route_req_t make_request();
        route_req_t  r;
        int          len;
        r.mode  = ($urandom_range(99) < 35) ? MODE_WRITE : MODE_LOOKUP;
        r.idx   = 4'($urandom_range(15));
        r.valid = ($urandom_range(99) < 85);
        r.addr  = $urandom;
        r.mask  = $urandom;
        r.gw    = $urandom;
        r.intf  = 4'($urandom_range(15));
        r.depth = 4'($urandom_range(HOP_LIMIT));
        if (r.mode == MODE_WRITE) begin
            if ($urandom_range(99) < 90) begin
                case ($urandom_range(4))
                    0: len = 32;
                    1: len = 24;
                    2: len = 16;
                    3: len = 8;
                    default: len = 0;
                endcase
                r.mask = (len == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - len));
                r.addr = addr_pool[$urandom_range(POOL_SIZE - 1)] & r.mask;
                if ($urandom_range(99) < 45)
                    r.gw = 32'h0;
                else if ($urandom_range(99) < 90)
                    r.gw = addr_pool[$urandom_range(POOL_SIZE - 1)];
            end
        end
        else if ($urandom_range(99) < 85) begin
            r.addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
            if ($urandom_range(1) == 1)
                r.addr = r.addr ^ 32'($urandom_range(255));
            if ($urandom_range(99) < 75)
                r.depth = 4'd0;
        end
        return r;
    endfunction

    task automatic send_req(input route_req_t r, input bit typed, input route_result_t want);
        route_result_t res;
        while (send_idle_pct != 0 && int'($urandom_range(99)) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        mode            <= r.mode;
        entry_index     <= r.idx;
        entry_valid     <= r.valid;
        addr            <= r.addr;
        dest_mask       <= r.mask;
        route_gateway   <= r.gw;
        route_interface <= r.intf;
        start_depth     <= r.depth;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = route_predict(r);
        if (r.mode == MODE_WRITE)
            n_write++;
        else if (res.status == ST_OK)
            n_routed++;
        else if (res.status == ST_NOROUTE)
            n_noroute++;
        else
            n_loop++;
        pending_results.push_back(typed ? want : res);
    endtask

    always @(posedge clk) begin
        if (hold_phase && !hold_used) begin
            hold_used <= 1'b1;
            hold_cnt  <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (hold_cnt > 0) begin
            hold_cnt  <= hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= (recv_stall_pct != 0) && (int'($urandom_range(99)) < recv_stall_pct);
        end
    end

    always @(posedge clk) begin
        route_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                if (fail_cnt < REPORT_MAX)
                    $display("tb_top: unexpected result status=%0d intf=%0d hop=%h",
                             status, out_interface, next_hop);
                fail_cnt++;
            end
            else begin
                want = pending_results.pop_front();
                if (status !== want.status || out_interface !== want.intf
                    || next_hop !== want.hop) begin
                    if (fail_cnt < REPORT_MAX)
                        $display("tb_top: mismatch status %0d/%0d intf %0d/%0d hop %h/%h",
                                 want.status, status, want.intf, out_interface,
                                 want.hop, next_hop);
                    fail_cnt++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT) begin
                $display("tb_top: no handshake for %0d cycles", IDLE_LIMIT);
                $display("tb_top: FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        route_result_t blank;
        blank = '{ST_OK, 4'd0, 32'h0};
        for (int i = 0; i < TBL_DEPTH; i++)
            rt_valid[i] = 1'b0;
        dir_rows = '{
            '{'{MODE_LOOKUP, 4'd0, 1'b0, 32'h0000_0000, 32'h0, 32'h0, 4'd0, 4'd0},
              1'b1, '{ST_NOROUTE, 4'd0, 32'h0}},
            '{'{MODE_LOOKUP, 4'd0, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'd0, 4'd10},
              1'b1, '{ST_NOROUTE, 4'd0, 32'h0}},
            '{'{MODE_WRITE, 4'd0, 1'b1, 32'h0A00_0000, 32'hFF00_0000, 32'h0, 4'd3, 4'd0},
              1'b1, '{ST_OK, 4'd0, 32'h0}},
            '{'{MODE_LOOKUP, 4'd0, 1'b0, 32'h0A12_3456, 32'h0, 32'h0, 4'd0, 4'd0},
              1'b1, '{ST_OK, 4'd3, 32'h0}},
            '{'{MODE_LOOKUP, 4'd0, 1'b0, 32'h0B00_0000, 32'h0, 32'h0, 4'd0, 4'd0},
              1'b1, '{ST_NOROUTE, 4'd0, 32'h0}},
            '{'{MODE_WRITE, 4'd1, 1'b1, 32'h0505_0505, 32'hFFFF_FFFF, 32'h0606_0606, 4'd2, 4'd0},
              1'b1, '{ST_OK, 4'd0, 32'h0}},
            '{'{MODE_LOOKUP, 4'd0, 1'b0, 32'h0505_0505, 32'h0, 32'h0, 4'd0, 4'd0},
              1'b1, '{ST_NOROUTE, 4'd0, 32'h0}},
            '{'{MODE_WRITE, 4'd2, 1'b1, 32'h0606_0600, 32'hFFFF_FF00, 32'h0, 4'd15, 4'd0},
              1'b1, '{ST_OK, 4'd0, 32'h0}},
            '{'{MODE_LOOKUP, 4'd0, 1'b0, 32'h0505_0505, 32'h0, 32'h0, 4'd0, 4'd0},
              1'b0, blank},
            '{'{MODE_LOOKUP, 4'd0, 1'b0, 32'h0505_0505, 32'h0, 32'h0, 4'd0, 4'd10},
              1'b1, '{ST_LOOP, 4'd0, 32'h0}},
            '{'{MODE_LOOKUP, 4'd0, 1'b0, 32'h0505_0505, 32'h0, 32'h0, 4'd0, 4'd15},
              1'b1, '{ST_LOOP, 4'd0, 32'h0}},
            '{'{MODE_LOOKUP, 4'd0, 1'b0, 32'h0505_0505, 32'h0, 32'h0, 4'd0, 4'd9},
              1'b0, blank},
            '{'{MODE_WRITE, 4'd3, 1'b1, 32'h0101_0101, 32'hFFFF_FFFF, 32'h0101_0101, 4'd1, 4'd0},
              1'b1, '{ST_OK, 4'd0, 32'h0}},
            '{'{MODE_LOOKUP, 4'd0, 1'b0, 32'h0101_0101, 32'h0, 32'h0, 4'd0, 4'd0},
              1'b1, '{ST_LOOP, 4'd0, 32'h0}},
            '{'{MODE_WRITE, 4'd4, 1'b1, 32'h0202_0202, 32'hFFFF_FFFF, 32'h0303_0303, 4'd4, 4'd0},
              1'b1, '{ST_OK, 4'd0, 32'h0}},
            '{'{MODE_WRITE, 4'd5, 1'b1, 32'h0303_0303, 32'hFFFF_FFFF, 32'h0202_0202, 4'd5, 4'd0},
              1'b1, '{ST_OK, 4'd0, 32'h0}},
            '{'{MODE_LOOKUP, 4'd0, 1'b0, 32'h0202_0202, 32'h0, 32'h0, 4'd0, 4'd0},
              1'b1, '{ST_LOOP, 4'd0, 32'h0}},
            '{'{MODE_WRITE, 4'd6, 1'b0, 32'h0A0A_0A0A, 32'hFFFF_FFFF, 32'h0, 4'd9, 4'd0},
              1'b1, '{ST_OK, 4'd0, 32'h0}},
            '{'{MODE_LOOKUP, 4'd0, 1'b0, 32'h0A0A_0A0A, 32'h0, 32'h0, 4'd0, 4'd0},
              1'b0, blank},
            '{'{MODE_WRITE, 4'd7, 1'b1, 32'h0, 32'h0, 32'h0606_0601, 4'd0, 4'd0},
              1'b1, '{ST_OK, 4'd0, 32'h0}},
            '{'{MODE_LOOKUP, 4'd0, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'd0, 4'd0},
              1'b0, blank},
            '{'{MODE_WRITE, 4'd15, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15,
                4'd0},
              1'b1, '{ST_OK, 4'd0, 32'h0}},
            '{'{MODE_LOOKUP, 4'd0, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'h0, 4'd0, 4'd0},
              1'b0, blank},
            '{'{MODE_WRITE, 4'd0, 1'b1, 32'h0, 32'h0, 32'h0, 4'd0, 4'd0},
              1'b1, '{ST_OK, 4'd0, 32'h0}},
            '{'{MODE_LOOKUP, 4'd0, 1'b0, 32'h1234_5678, 32'h0, 32'h0, 4'd0, 4'd0},
              1'b1, '{ST_OK, 4'd0, 32'h0}}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 0;
                    hold_phase     <= 1'b1;
                end
                1: begin
                    send_idle_pct   = 48;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct   = 0;
                    recv_stall_pct <= 48;
                end
                default: begin
                    send_idle_pct   = 11;
                    recv_stall_pct <= 11;
                end
            endcase
            foreach (addr_pool[k])
                addr_pool[k] = $urandom;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_req(make_request(), 1'b0, blank);
        end
        in_valid <= 1'b0;

        // drain, then allow one full worst-case lookup
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        fail_cnt += pending_results.size();

        $display("tb_top: %0d requests: %0d table writes, lookups %0d routed, %0d no route, %0d loop",
                 n_write + n_routed + n_noroute + n_loop, n_write, n_routed, n_noroute, n_loop);
        $display("tb_top: idle mixes none/sender/receiver/both, one %0d-cycle hold-off, %0d errors",
                 HOLD_CYCLES, fail_cnt);
        if (fail_cnt == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/rtgl_pkg.sv
hw/rtl/rtgl_table.sv
hw/rtl/route_table_gateway_lookup.sv
tb/tb_top.sv
